// ===== rtl/nat_pkg.sv =====
// ----------------------------------------------------------------------------
// nat_pkg: shared types and constants of the NAPT connection table
// Commands, status codes, front-to-back word and sequencer states.
// ----------------------------------------------------------------------------
package nat_pkg;

  localparam int unsigned MAP_ENTRIES_DEF  = 64;
  localparam int unsigned RULE_ENTRIES_DEF = 8;
  localparam int unsigned PORT_FIRST_DEF   = 32768;
  localparam int unsigned PORT_END_DEF     = 33792;

  typedef enum logic [1:0] {
    CMD_OUT  = 2'd0,
    CMD_IN   = 2'd1,
    CMD_RULE = 2'd2,
    CMD_TICK = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_HIT       = 4'd0,
    ST_NEW       = 4'd1,
    ST_UNMATCHED = 4'd2,
    ST_WRONG_DST = 4'd3,
    ST_NO_PORT   = 4'd4,
    ST_FULL      = 4'd5,
    ST_RULE_ADD  = 4'd6,
    ST_RULE_FULL = 4'd7,
    ST_TICK      = 4'd8
  } status_t;

  // Word handed from the front (accept and classify) to the back (execute).
  typedef struct packed {
    cmd_t        cmd;
    logic        wrong_dst;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [31:0] dst_addr;
    logic [15:0] dst_port;
  } job_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SCAN,
    B_PORT,
    B_FILL,
    B_RULE,
    B_TICK,
    B_DONE
  } bstate_t;

endpackage

// ===== rtl/nat_ram.sv =====
// ----------------------------------------------------------------------------
// nat_ram: generic simple dual-port RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/nat_front.sv =====
// ----------------------------------------------------------------------------
// nat_front: input acceptance, classification and a two-word queue
// Flag inbound packets for a foreign destination and hand words to the back.
// ----------------------------------------------------------------------------
module nat_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_command,
  input  logic [31:0]   in_source_address,
  input  logic [15:0]   in_source_port,
  input  logic [31:0]   in_dest_address,
  input  logic [15:0]   in_dest_port,
  input  logic [31:0]   ext_addr,
  output nat_pkg::job_t job,
  output logic          job_valid,
  input  logic          job_take
);
  import nat_pkg::*;

  job_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  job_t       nj;

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];

  always_comb begin
    nj.cmd       = cmd_t'(in_command);
    nj.wrong_dst = (in_dest_address != ext_addr);
    nj.src_addr  = in_source_address;
    nj.src_port  = in_source_port;
    nj.dst_addr  = in_dest_address;
    nj.dst_port  = in_dest_port;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= nj;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (job_take) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, job_take};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) job_take |-> job_valid)
    else $error("take from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !job_take) |=> cnt_r == 2'd2)
    else $error("full queue lost a word");
endmodule

// ===== rtl/nat_back.sv =====
// ----------------------------------------------------------------------------
// nat_back: table sequencer
// Scan mappings over cycles, search free ports, add rules, expire on ticks.
// ----------------------------------------------------------------------------
module nat_back #(
  parameter int unsigned MAP_ENTRIES  = nat_pkg::MAP_ENTRIES_DEF,
  parameter int unsigned RULE_ENTRIES = nat_pkg::RULE_ENTRIES_DEF,
  parameter int unsigned PORT_FIRST   = nat_pkg::PORT_FIRST_DEF,
  parameter int unsigned PORT_END     = nat_pkg::PORT_END_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  nat_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_take,
  input  logic [31:0]   ext_addr,
  input  logic [15:0]   idle_to,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [3:0]    out_status,
  output logic [31:0]   out_new_address,
  output logic [15:0]   out_new_port,
  output logic [6:0]    out_expired_count
);
  import nat_pkg::*;

  localparam int unsigned MW    = $clog2(MAP_ENTRIES);
  localparam int unsigned RW    = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
  localparam int unsigned SPAN  = (PORT_END > PORT_FIRST) ? PORT_END - PORT_FIRST : 0;
  localparam int unsigned SLOTS = (SPAN > 0) ? SPAN : 1;
  localparam int unsigned PW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [15:0] PF16  = 16'(PORT_FIRST);
  localparam logic [16:0] PF17  = 17'(PORT_FIRST);
  localparam logic [16:0] PE17  = 17'(PORT_END);

  // Entry layout: remote addr, remote port, inside addr, inside port,
  // outside port, stamp. Outside address of a mapping is kept separately.
  typedef struct packed {
    logic [31:0] ra;
    logic [15:0] rp;
    logic [31:0] ia;
    logic [15:0] ip;
    logic [15:0] op;
    logic [31:0] st;
  } ent_t;

  bstate_t st_r, st_nxt;
  job_t    j_r;
  logic    [MAP_ENTRIES-1:0] mval_r;
  logic    [RULE_ENTRIES-1:0] rval_r;
  logic    [31:0] r_oa_r [RULE_ENTRIES];
  logic    [15:0] r_op_r [RULE_ENTRIES];
  logic    [31:0] r_ia_r [RULE_ENTRIES];
  logic    [15:0] r_ip_r [RULE_ENTRIES];
  logic    [31:0] now_r;
  logic    [MW:0] idx_r;       // read address issued
  logic    [MW:0] chk_r;       // entry whose data is on rdata
  logic    chk_v_r;
  logic    [PW:0] pidx_r;
  logic    pchk_v_r;
  logic    [PW:0] pchk_r;
  logic    [3:0]  ost_r;
  logic    [31:0] oaddr_r;
  logic    [15:0] oport_r;
  logic    [6:0]  oexp_r;
  logic    ovalid_r;
  // Result word held on the output while the next item is worked on
  logic    [3:0]  res_st_r;
  logic    [31:0] res_addr_r;
  logic    [15:0] res_port_r;
  logic    [6:0]  res_exp_r;

  // Memories
  logic          m_we;
  logic [MW-1:0] m_wa, m_ra;
  ent_t          m_wd, m_rd;
  logic [31:0]   oa_wd, oa_rd;
  logic          p_we;
  logic [PW-1:0] p_wa, p_ra;
  logic          p_wd, p_rd;

  nat_ram #(.WIDTH($bits(ent_t)), .DEPTH(MAP_ENTRIES)) u_map (
    .clk, .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
  nat_ram #(.WIDTH(32), .DEPTH(MAP_ENTRIES)) u_moa (
    .clk, .we(m_we), .waddr(m_wa), .wdata(oa_wd), .raddr(m_ra), .rdata(oa_rd));

  // Port bitmap: one bit per dynamic port. Reset by a clearing pass that
  // reuses the port search index; no item is taken until it finishes.
  logic clr_r;
  nat_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_port (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

  logic [MW:0]   free_slot;
  logic          free_any;
  logic [RW-1:0] rfree;
  logic          rfree_any;
  logic [RW-1:0] rmatch;
  logic          rmatch_any;
  logic          match;
  logic          exp_now;
  logic          owned;
  logic          op_in;
  logic [15:0]   opd;
  logic          pfound;

  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = MAP_ENTRIES - 1; i >= 0; i--) begin
      if (!mval_r[i]) begin
        free_any  = 1'b1;
        free_slot = (MW+1)'(i);
      end
    end
    rfree_any = 1'b0;
    rfree     = '0;
    rmatch_any = 1'b0;
    rmatch     = '0;
    owned      = 1'b0;
    for (int r = RULE_ENTRIES - 1; r >= 0; r--) begin
      if (!rval_r[r]) begin
        rfree_any = 1'b1;
        rfree     = RW'(r);
      end
      if (rval_r[r] && r_oa_r[r] == j_r.dst_addr && r_op_r[r] == j_r.dst_port) begin
        rmatch_any = 1'b1;
        rmatch     = RW'(r);
      end
      if (rval_r[r] && r_op_r[r] == m_rd.op) owned = 1'b1;
    end
  end

  always_comb begin
    if (j_r.cmd == CMD_OUT) begin
      match = m_rd.ra == j_r.dst_addr && m_rd.rp == j_r.dst_port &&
              m_rd.ia == j_r.src_addr && m_rd.ip == j_r.src_port;
    end else begin
      match = m_rd.ra == j_r.src_addr && m_rd.rp == j_r.src_port &&
              oa_rd == j_r.dst_addr && m_rd.op == j_r.dst_port;
    end
    exp_now = (now_r - m_rd.st) > {16'd0, idle_to};
    op_in   = ({1'b0, m_rd.op} >= PF17) && ({1'b0, m_rd.op} < PE17);
    opd     = m_rd.op - PF16;
  end

  logic chk_ok;
  assign chk_ok = chk_v_r && mval_r[chk_r[MW-1:0]];
  assign pfound = pchk_v_r && !p_rd;

  assign job_take          = (st_r == B_IDLE) && job_valid && !clr_r;
  assign out_valid         = ovalid_r;
  assign out_status        = res_st_r;
  assign out_new_address   = res_addr_r;
  assign out_new_port      = res_port_r;
  assign out_expired_count = res_exp_r;

  always_comb begin
    st_nxt = st_r;
    m_we = 1'b0; m_wa = chk_r[MW-1:0]; m_wd = m_rd; oa_wd = oa_rd;
    m_ra = idx_r[MW-1:0];
    p_we = clr_r; p_wa = pidx_r[PW-1:0]; p_wd = 1'b0;
    p_ra = pidx_r[PW-1:0];
    unique case (st_r)
      B_IDLE: begin
        if (job_take) begin
          unique case (job.cmd)
            CMD_RULE: st_nxt = B_RULE;
            CMD_TICK: st_nxt = B_TICK;
            CMD_IN:   st_nxt = job.wrong_dst ? B_DONE : B_SCAN;
            default:  st_nxt = B_SCAN;
          endcase
        end
      end
      B_SCAN: begin
        if (chk_ok && match) begin
          // Refresh timestamp of the lowest hit.
          m_we = 1'b1; m_wa = chk_r[MW-1:0]; m_wd.st = now_r;
          st_nxt = B_DONE;
        end else if (!chk_v_r && idx_r == (MW+1)'(MAP_ENTRIES) ||
                     chk_v_r && chk_r == (MW+1)'(MAP_ENTRIES - 1)) begin
          if (!free_any) st_nxt = B_DONE;
          else if (j_r.cmd == CMD_OUT) st_nxt = (SPAN == 0) ? B_DONE : B_PORT;
          else st_nxt = rmatch_any ? B_FILL : B_DONE;
        end
      end
      B_PORT: begin
        if (pfound) begin
          p_we = 1'b1; p_wa = pchk_r[PW-1:0]; p_wd = 1'b1;
          st_nxt = B_FILL;
        end else if (pchk_v_r && pchk_r == (PW+1)'(SLOTS - 1)) begin
          st_nxt = B_DONE;
        end
      end
      B_FILL: begin
        m_we = 1'b1; m_wa = free_slot[MW-1:0];
        m_wd.st = now_r;
        if (j_r.cmd == CMD_OUT) begin
          m_wd.ra = j_r.dst_addr; m_wd.rp = j_r.dst_port;
          m_wd.ia = j_r.src_addr; m_wd.ip = j_r.src_port;
          m_wd.op = PF16 + 16'(pchk_r);
          oa_wd   = ext_addr;
        end else begin
          m_wd.ra = j_r.src_addr; m_wd.rp = j_r.src_port;
          m_wd.ia = r_ia_r[rmatch]; m_wd.ip = r_ip_r[rmatch];
          m_wd.op = j_r.dst_port;
          oa_wd   = j_r.dst_addr;
        end
        st_nxt = B_DONE;
      end
      B_RULE: begin
        if (rfree_any && ({1'b0, j_r.src_port} >= PF17) &&
            ({1'b0, j_r.src_port} < PE17)) begin
          p_we = 1'b1; p_wa = PW'(j_r.src_port - PF16); p_wd = 1'b1;
        end
        st_nxt = B_DONE;
      end
      B_TICK: begin
        if (chk_ok && exp_now && op_in && !owned) begin
          p_we = 1'b1; p_wa = PW'(opd); p_wd = 1'b0;
        end
        if (chk_v_r && chk_r == (MW+1)'(MAP_ENTRIES - 1)) st_nxt = B_DONE;
      end
      B_DONE: begin
        if (!ovalid_r || out_ready) st_nxt = B_IDLE;
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (job_take) j_r <= job;
    if (st_r == B_RULE && rfree_any) begin
      r_oa_r[rfree] <= j_r.src_addr; r_op_r[rfree] <= j_r.src_port;
      r_ia_r[rfree] <= j_r.dst_addr; r_ip_r[rfree] <= j_r.dst_port;
    end
    if (!rst_n) begin
      st_r <= B_IDLE; mval_r <= '0; rval_r <= '0; now_r <= '0;
      idx_r <= '0; chk_r <= '0; chk_v_r <= 1'b0; pidx_r <= '0;
      pchk_r <= '0; pchk_v_r <= 1'b0;
      ovalid_r <= 1'b0; ost_r <= '0; oaddr_r <= '0; oport_r <= '0;
      oexp_r <= '0; clr_r <= 1'b1;
      res_st_r <= '0; res_addr_r <= '0; res_port_r <= '0; res_exp_r <= '0;
    end else begin
      st_r <= st_nxt;
      // Load the result word once the previous one has left.
      if (st_r == B_DONE && (!ovalid_r || out_ready)) begin
        ovalid_r   <= 1'b1;
        res_st_r   <= ost_r;
        res_addr_r <= oaddr_r;
        res_port_r <= oport_r;
        res_exp_r  <= oexp_r;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
      if (clr_r) begin
        pidx_r <= pidx_r + 1'b1;
        if (pidx_r == (PW+1)'(SLOTS - 1)) begin
          clr_r <= 1'b0; pidx_r <= '0;
        end
      end
      chk_v_r <= 1'b0;
      pchk_v_r <= 1'b0;
      unique case (st_r)
        B_IDLE: begin
          idx_r <= '0;
          if (!clr_r) pidx_r <= '0;
          oexp_r <= '0; oaddr_r <= '0; oport_r <= '0;
          if (job_take) begin
            if (job.cmd == CMD_TICK) now_r <= now_r + 32'd1;
            ost_r <= (job.cmd == CMD_IN && job.wrong_dst) ? ST_WRONG_DST : ST_HIT;
          end
        end
        B_SCAN, B_TICK: begin
          if (idx_r != (MW+1)'(MAP_ENTRIES)) begin
            idx_r <= idx_r + 1'b1; chk_v_r <= 1'b1; chk_r <= idx_r;
          end
          if (st_r == B_SCAN && chk_ok && match) begin
            ost_r <= ST_HIT;
            oaddr_r <= (j_r.cmd == CMD_OUT) ? oa_rd : m_rd.ia;
            oport_r <= (j_r.cmd == CMD_OUT) ? m_rd.op : m_rd.ip;
          end else if (st_r == B_SCAN && st_nxt != B_SCAN) begin
            if (!free_any) ost_r <= (j_r.cmd == CMD_IN && !rmatch_any) ?
                                     ST_UNMATCHED : ST_FULL;
            else if (j_r.cmd == CMD_OUT) ost_r <= ST_NO_PORT;
            else ost_r <= rmatch_any ? ST_NEW : ST_UNMATCHED;
          end
          if (st_r == B_TICK) begin
            ost_r <= ST_TICK;
            if (chk_ok && exp_now) begin
              mval_r[chk_r[MW-1:0]] <= 1'b0;
              if (oexp_r != 7'd127) oexp_r <= oexp_r + 7'd1;
            end
          end
        end
        B_PORT: begin
          // Hold the index of a free port for the fill step.
          if (pidx_r != (PW+1)'(SLOTS) && !pfound) begin
            pidx_r <= pidx_r + 1'b1; pchk_v_r <= 1'b1; pchk_r <= pidx_r;
          end
          if (pfound) ost_r <= ST_NEW;
        end
        B_FILL: begin
          mval_r[free_slot[MW-1:0]] <= 1'b1;
          oaddr_r <= (j_r.cmd == CMD_OUT) ? ext_addr : r_ia_r[rmatch];
          oport_r <= (j_r.cmd == CMD_OUT) ? PF16 + 16'(pchk_r) : r_ip_r[rmatch];
        end
        B_RULE: begin
          ost_r <= rfree_any ? ST_RULE_ADD : ST_RULE_FULL;
          if (rfree_any) rval_r[rfree] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_DONE && ovalid_r && !out_ready) |=> st_r == B_DONE)
    else $error("result overwritten");
  assert property (@(posedge clk) disable iff (!rst_n) clr_r |-> !job_take)
    else $error("item taken during port clear");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_FILL) |-> free_any)
    else $error("fill without free slot");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_status) && $stable(out_new_address) &&
                                  $stable(out_new_port) && $stable(out_expired_count))
    else $error("result word changed while waiting");
endmodule

// ===== rtl/nat_port_mapping_table_unit.sv =====
// ----------------------------------------------------------------------------
// nat_port_mapping_table_unit: NAPT connection table
// Front queue plus table sequencer.
// ----------------------------------------------------------------------------
// Packets scan the mappings up to a hit, one mapping read per cycle, plus a
//   free-port search on a new outbound flow; ticks scan every mapping; rule
//   adds need no scan.
// Throughput: one item at a time through the table sequencer.
// Reset: synchronous; after reset a pass clears the port bitmap, one port a
//   cycle, while no item is taken.
module nat_port_mapping_table_unit #(
  parameter int unsigned MAP_ENTRIES  = nat_pkg::MAP_ENTRIES_DEF,
  parameter int unsigned RULE_ENTRIES = nat_pkg::RULE_ENTRIES_DEF,
  parameter int unsigned PORT_FIRST   = nat_pkg::PORT_FIRST_DEF,
  parameter int unsigned PORT_END     = nat_pkg::PORT_END_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_source_address,
  input  logic [15:0] in_source_port,
  input  logic [31:0] in_dest_address,
  input  logic [15:0] in_dest_port,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_status,
  output logic [31:0] out_new_address,
  output logic [15:0] out_new_port,
  output logic [6:0]  out_expired_count
);
  import nat_pkg::*;

  localparam logic CFG_EXT = 1'b0;

  logic [31:0] ext_r;
  logic [15:0] to_r;
  job_t        job;
  logic        job_valid, job_take;

  // Hold configuration registers; the user must write them only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r <= '0;
      to_r  <= 16'd60;
    end else if (cfg_we) begin
      if (cfg_index == CFG_EXT) ext_r <= cfg_data;
      else to_r <= cfg_data[15:0];
    end
  end

  // Front: accept and classify words into a two-deep queue.
  nat_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_source_address,
    .in_source_port, .in_dest_address, .in_dest_port,
    .ext_addr(ext_r), .job, .job_valid, .job_take);

  // Back: walk the tables and register the result word.
  nat_back #(
    .MAP_ENTRIES(MAP_ENTRIES), .RULE_ENTRIES(RULE_ENTRIES),
    .PORT_FIRST(PORT_FIRST), .PORT_END(PORT_END)
  ) u_back (
    .clk, .rst_n, .job, .job_valid, .job_take,
    .ext_addr(ext_r), .idle_to(to_r),
    .out_valid, .out_ready, .out_status, .out_new_address,
    .out_new_port, .out_expired_count);
endmodule
